[hw/rtl/sat_pkg.sv]
// ----------------------------------------------------------------------------
// sat_pkg: section address translator shared types
// Request codes, section descriptor layout and the record types passed
// between the table, the compare unit and the sequencer.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int MAX_SECTIONS_DEFAULT = 16;

  localparam int OP_W       = 2;
  localparam int ENTRY_IDX_W = 4;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 5;
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 40;

  localparam logic [OP_W-1:0] OP_WRITE      = 2'd0;
  localparam logic [OP_W-1:0] OP_VIRT_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_FILE_QUERY = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] file_len;
    logic [ADDR_W-1:0] raw_start;
    logic [ADDR_W-1:0] mem_len;
    logic [ADDR_W-1:0] virtual_start;
  } entry_t;

  typedef struct packed {
    logic                   en;
    logic [ENTRY_IDX_W-1:0] index;
    entry_t                 data;
  } table_wr_t;

  typedef struct packed {
    logic              raw_match;
    logic              span_match;
    logic [ADDR_W-1:0] addr;
  } match_t;

  typedef struct packed {
    logic [ENTRY_IDX_W-1:0] section_index;
    logic                   section_hit;
    logic [ADDR_W-1:0]      translated_address;
    logic                   raw_hit;
  } result_t;

endpackage

[hw/rtl/section_address_translator.sv]
// ----------------------------------------------------------------------------
// section_address_translator: base-and-limit section address translation
// A query reads the first n entries (n = section_count capped at MAX_SECTIONS),
// one descriptor read and compared a cycle, then registers its result; a write
// request goes straight to the result register. A new request is taken only
// once the last result is loaded for the output; a result stalled on m_tready
// holds the next result back.
// Reset: synchronous; clears the section count to zero and the output valid;
// table contents are undefined until written.
// ----------------------------------------------------------------------------
module section_address_translator #(
  parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [sat_pkg::COUNT_W-1:0]        cfg_wr_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // entry_index, entry virtual start, entry virtual length, entry raw start,
  // entry raw length, query_address, zero pad
  input  logic [sat_pkg::IN_DATA_W-1:0]      s_tdata,
  // op
  input  logic [sat_pkg::OP_W-1:0]           s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // raw_hit, translated_address, section_hit, section_index, zero pad
  output logic [sat_pkg::OUT_DATA_W-1:0]     m_tdata
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  sat_pkg::table_wr_t         wr;
  sat_pkg::entry_t            rd_data;
  sat_pkg::match_t            match;
  sat_pkg::result_t           result;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [sat_pkg::OP_W-1:0]   op;
  logic [sat_pkg::ADDR_W-1:0] query;

  assign wr.en                 = s_tvalid && s_tready && (s_tuser == sat_pkg::OP_WRITE);
  assign wr.index              = s_tdata[3:0];
  assign wr.data.virtual_start = s_tdata[35:4];
  assign wr.data.mem_len       = s_tdata[67:36];
  assign wr.data.raw_start     = s_tdata[99:68];
  assign wr.data.file_len      = s_tdata[131:100];

  sat_table #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_table (
    .clk    (clk),
    .wr     (wr),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sat_unit u_unit (
    .op   (op),
    .query(query),
    .entry(rd_data),
    .match(match)
  );

  sat_ctrl #(
    .MAX_SECTIONS(MAX_SECTIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .in_op      (s_tuser),
    .in_query   (s_tdata[163:132]),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .result     (result),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .op         (op),
    .query      (query),
    .match      (match)
  );

  assign m_tdata = {2'b00, result};

endmodule

[hw/rtl/sat_table.sv]
// ----------------------------------------------------------------------------
// sat_table: section descriptor store
// One write port and one registered read port over the descriptor memory.
// ----------------------------------------------------------------------------
module sat_table #(
  parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEFAULT
) (
  input  logic                clk,
  input  sat_pkg::table_wr_t  wr,
  input  logic                rd_en,
  input  logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] rd_addr,
  output sat_pkg::entry_t     rd_data
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;

  sat_pkg::entry_t mem [MAX_SECTIONS];
  logic            wr_ok;

  assign wr_ok = wr.en && ({28'd0, wr.index} < 32'(MAX_SECTIONS));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[IDX_W'(wr.index)] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/sat_unit.sv]
// ----------------------------------------------------------------------------
// sat_unit: shared window compare and translate unit
// Checks one descriptor against the query at 33 bits and forms the
// translated address for that descriptor.
// ----------------------------------------------------------------------------
module sat_unit (
  input  logic [sat_pkg::OP_W-1:0]   op,
  input  logic [sat_pkg::ADDR_W-1:0] query,
  input  sat_pkg::entry_t            entry,
  output sat_pkg::match_t            match
);

  logic                        virt;
  logic [sat_pkg::ADDR_W-1:0]  base;
  logic [sat_pkg::ADDR_W-1:0]  other;
  logic [sat_pkg::ADDR_W-1:0]  span_size;
  logic [sat_pkg::ADDR_W:0]    raw_end;
  logic [sat_pkg::ADDR_W:0]    span_end;
  logic                        above_base;

  assign virt  = (op == sat_pkg::OP_VIRT_QUERY);
  assign base  = virt ? entry.virtual_start : entry.raw_start;
  assign other = virt ? entry.raw_start : entry.virtual_start;

  always_comb begin
    span_size = entry.file_len;
    if (virt && (entry.mem_len > entry.file_len)) begin
      span_size = entry.mem_len;
    end
  end

  assign raw_end    = {1'b0, base} + {1'b0, entry.file_len};
  assign span_end   = {1'b0, base} + {1'b0, span_size};
  assign above_base = (query >= base);

  assign match.raw_match  = above_base && ({1'b0, query} < raw_end);
  assign match.span_match = above_base && ({1'b0, query} < span_end);
  assign match.addr       = query - base + other;

endmodule

[hw/rtl/sat_ctrl.sv]
// ----------------------------------------------------------------------------
// sat_ctrl: lookup sequencer
// Takes requests, walks the table one entry a cycle through the shared
// unit, keeps the first matches and holds the result for the output.
// ----------------------------------------------------------------------------
module sat_ctrl #(
  parameter int MAX_SECTIONS = sat_pkg::MAX_SECTIONS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [sat_pkg::COUNT_W-1:0]      cfg_wr_data,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [sat_pkg::OP_W-1:0]         in_op,
  input  logic [sat_pkg::ADDR_W-1:0]       in_query,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output sat_pkg::result_t                 result,
  output logic                             rd_en,
  output logic [((MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1)-1:0] rd_addr,
  output logic [sat_pkg::OP_W-1:0]         op,
  output logic [sat_pkg::ADDR_W-1:0]       query,
  input  sat_pkg::match_t                  match
);

  localparam int IDX_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                     state;
  logic [sat_pkg::COUNT_W-1:0] section_count;
  logic [CNT_W-1:0]           searched;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           ptr;
  logic                       eval_valid;
  logic [IDX_W-1:0]           eval_idx;
  logic                       raw_hit;
  logic                       sec_hit;
  logic [sat_pkg::ADDR_W-1:0] addr;
  logic [IDX_W-1:0]           idx;
  logic                       is_query;
  logic                       load;

  assign searched = ({27'd0, section_count} > 32'(MAX_SECTIONS)) ?
                    CNT_W'(MAX_SECTIONS) : CNT_W'(section_count);
  assign is_query = (in_op == sat_pkg::OP_VIRT_QUERY) ||
                    (in_op == sat_pkg::OP_FILE_QUERY);

  assign s_tready = (state == ST_IDLE);
  assign rd_en    = (state == ST_SCAN) && (ptr < count);
  assign rd_addr  = ptr[IDX_W-1:0];
  assign load     = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      eval_valid    <= 1'b0;
      section_count <= '0;
    end else begin
      if (cfg_wr_en) begin
        section_count <= cfg_wr_data;
      end
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op         <= in_op;
            query      <= in_query;
            ptr        <= '0;
            eval_valid <= 1'b0;
            raw_hit    <= 1'b0;
            sec_hit    <= 1'b0;
            addr       <= '0;
            idx        <= '0;
            count      <= is_query ? searched : '0;
            state      <= is_query ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          eval_valid <= rd_en;
          eval_idx   <= ptr[IDX_W-1:0];
          if (rd_en) begin
            ptr <= ptr + 1'b1;
          end
          if (eval_valid) begin
            if (match.raw_match && !raw_hit) begin
              raw_hit <= 1'b1;
              addr    <= match.addr;
            end
            if (match.span_match && !sec_hit) begin
              sec_hit <= 1'b1;
              idx     <= eval_idx;
            end
          end
          if (!rd_en && !eval_valid) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load) begin
            result.raw_hit            <= raw_hit;
            result.translated_address <= addr;
            result.section_hit        <= sec_hit;
            result.section_index      <= sat_pkg::ENTRY_IDX_W'(idx);
            state                     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/sat_checker.sv]
// ----------------------------------------------------------------------------
// sat_checker: port-level checks for the section address translator
// Watches the request, result and reset behaviour seen at the top level.
// ----------------------------------------------------------------------------
module sat_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [sat_pkg::OUT_DATA_W-1:0] m_tdata
);

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready stayed high after a request");

  a_reset_clears_valid: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  a_miss_fields_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[0] || (m_tdata[32:1] == 32'd0)) &&
                  (m_tdata[33] || (m_tdata[37:34] == 4'd0)) &&
                  (m_tdata[39:38] == 2'd0)))
    else $error("miss result carries non-zero fields");

endmodule

bind section_address_translator sat_checker u_sat_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

[dv/tb_section_address_translator.sv]
// ----------------------------------------------------------------------------
// tb_section_address_translator: self-checking bench for the section translator
// Loads the descriptor table, then runs directed and random write, virtual
// and file-offset requests over several section counts. Each accepted request
// is predicted by the scoreboard and every result is compared field by field.
// ----------------------------------------------------------------------------
class translation_board;
  sat_pkg::entry_t  sections [sat_pkg::MAX_SECTIONS_DEFAULT];
  logic [4:0]       section_count;
  sat_pkg::result_t pending_translations [$];
  int               errors;

  function new();
    section_count = '0;
    errors = 0;
  endfunction

  function void set_count(logic [4:0] value);
    section_count = value;
  endfunction

  function int pending();
    return pending_translations.size();
  endfunction

  function bit in_window(logic [31:0] q, logic [31:0] base, logic [31:0] size);
    logic [32:0] limit;
    limit = {1'b0, base} + {1'b0, size};
    return ({1'b0, q} >= {1'b0, base}) && ({1'b0, q} < limit);
  endfunction

  function sat_pkg::result_t translate(logic [1:0] op, logic [31:0] q);
    sat_pkg::result_t r;
    sat_pkg::entry_t  e;
    logic [31:0]      span;
    int               n;
    r = '0;
    n = (section_count > sat_pkg::MAX_SECTIONS_DEFAULT) ? sat_pkg::MAX_SECTIONS_DEFAULT
                                                         : int'(section_count);
    for (int i = 0; i < n; i++) begin
      e = sections[i];
      if (op == sat_pkg::OP_VIRT_QUERY) begin
        span = (e.mem_len > e.file_len) ? e.mem_len : e.file_len;
        if (!r.raw_hit && in_window(q, e.virtual_start, e.file_len)) begin
          r.raw_hit = 1'b1;
          r.translated_address = q - e.virtual_start + e.raw_start;
        end
        if (!r.section_hit && in_window(q, e.virtual_start, span)) begin
          r.section_hit = 1'b1;
          r.section_index = 4'(i);
        end
      end else if (op == sat_pkg::OP_FILE_QUERY) begin
        if (!r.raw_hit && in_window(q, e.raw_start, e.file_len)) begin
          r.raw_hit = 1'b1;
          r.translated_address = q - e.raw_start + e.virtual_start;
          r.section_hit = 1'b1;
          r.section_index = 4'(i);
        end
      end
    end
    return r;
  endfunction

  function void note_request(logic [1:0] op, logic [167:0] data);
    sat_pkg::entry_t  e;
    sat_pkg::result_t blank;
    blank = '0;
    e.virtual_start = data[35:4];
    e.mem_len       = data[67:36];
    e.raw_start     = data[99:68];
    e.file_len      = data[131:100];
    if (op == sat_pkg::OP_WRITE) begin
      sections[data[3:0]] = e;
      pending_translations.push_back(blank);
    end else begin
      pending_translations.push_back(translate(op, data[163:132]));
    end
  endfunction

  function void check_result(logic [39:0] data);
    sat_pkg::result_t got;
    sat_pkg::result_t want;
    got = data[37:0];
    if (pending_translations.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, data);
      errors++;
      return;
    end
    want = pending_translations.pop_front();
    if (got.raw_hit != want.raw_hit) begin
      $display("%0t: raw_hit expected %0d actual %0d", $time, want.raw_hit, got.raw_hit);
      errors++;
    end
    if (got.translated_address != want.translated_address) begin
      $display("%0t: translated_address expected %h actual %h", $time,
               want.translated_address, got.translated_address);
      errors++;
    end
    if (got.section_hit != want.section_hit) begin
      $display("%0t: section_hit expected %0d actual %0d", $time,
               want.section_hit, got.section_hit);
      errors++;
    end
    if (got.section_index != want.section_index) begin
      $display("%0t: section_index expected %0d actual %0d", $time,
               want.section_index, got.section_index);
      errors++;
    end
  endfunction
endclass

module tb_section_address_translator;

  localparam int SECTIONS      = sat_pkg::MAX_SECTIONS_DEFAULT;
  localparam logic [sat_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 160;

  logic                           clk;
  logic                           rst;
  logic                           cfg_wr_en;
  logic [sat_pkg::COUNT_W-1:0]    cfg_wr_data;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [sat_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [sat_pkg::OP_W-1:0]       s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [sat_pkg::OUT_DATA_W-1:0] m_tdata;

  translation_board board;

  logic [31:0] plan_vs  [SECTIONS];
  logic [31:0] plan_vsz [SECTIONS];
  logic [31:0] plan_rs  [SECTIONS];
  logic [31:0] plan_rsz [SECTIONS];
  int          searched;
  int          burst_left;
  int          cycles;
  int          stall_mode;
  int          stall_left;
  logic [4:0]  phase_counts [6] = '{5'd16, 5'd0, 5'd17, 5'd1, 5'd31, 5'd15};

  section_address_translator #(
    .MAX_SECTIONS(SECTIONS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      board.note_request(s_tuser, s_tdata);
    end
    if (!rst && m_tvalid && m_tready) begin
      board.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        m_tready <= 1'b1;
      end
      1: begin
        m_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_tready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        m_tready <= 1'b0;
      end
    endcase
  end

  task automatic send_request(input logic [1:0] op,
                              input logic [sat_pkg::IN_DATA_W-1:0] data);
    s_tuser  <= op;
    s_tdata  <= data;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic hold_off(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_section_count(input logic [4:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.set_count(value);
    searched = (value > SECTIONS) ? SECTIONS : int'(value);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 24));
    end
    burst_left--;
  endtask

  task automatic write_entry(input logic [3:0] idx, input logic [31:0] vs,
                             input logic [31:0] vsz, input logic [31:0] rs,
                             input logic [31:0] rsz);
    logic [31:0] noise;
    noise = $urandom();
    plan_vs[idx]  = vs;
    plan_vsz[idx] = vsz;
    plan_rs[idx]  = rs;
    plan_rsz[idx] = rsz;
    send_request(sat_pkg::OP_WRITE, {4'b0, noise, rsz, rs, vsz, vs, idx});
  endtask

  task automatic write_random_entry(input logic [3:0] idx);
    logic [31:0] vs, vsz, rs, rsz;
    int          mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      vs  = 32'h0001_0000 + $urandom_range(0, 4095);
      vsz = $urandom_range(0, 1024);
      rs  = 32'h0000_8000 + $urandom_range(0, 4095);
      rsz = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(0, 1024));
    end else if (mode < 8) begin
      vs  = $urandom();
      vsz = $urandom();
      rs  = $urandom();
      rsz = $urandom();
    end else begin
      vs  = 32'hFFFF_FFFF - $urandom_range(0, 4095);
      vsz = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 15)
                                 : 32'($urandom_range(0, 8191));
      rs  = 32'hFFFF_FFFF - $urandom_range(0, 4095);
      rsz = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 15)
                                 : 32'($urandom_range(0, 8191));
    end
    write_entry(idx, vs, vsz, rs, rsz);
  endtask

  task automatic send_query(input logic [1:0] op, input logic [31:0] q);
    logic [31:0] a, b, c, d;
    logic [3:0]  idx;
    a = $urandom();
    b = $urandom();
    c = $urandom();
    d = $urandom();
    idx = $urandom_range(0, 15);
    send_request(op, {4'b0, q, a, b, c, d, idx});
  endtask

  // aim at the edges and the inside of one section's windows
  function automatic logic [31:0] near_address(input logic [1:0] op, input int i);
    logic [31:0] base, size, other, span;
    base  = (op == sat_pkg::OP_FILE_QUERY) ? plan_rs[i] : plan_vs[i];
    size  = plan_rsz[i];
    other = (op == sat_pkg::OP_FILE_QUERY) ? plan_rsz[i] : plan_vsz[i];
    span  = (size > other) ? size : other;
    case ($urandom_range(0, 6))
      0: return base - 32'd1;
      1: return base;
      2: return base + size - 32'd1;
      3: return base + size;
      4: return base + other - 32'd1;
      5: return base + other;
      default: return (span == 0) ? base : base + ($urandom() % span);
    endcase
  endfunction

  initial begin
    int kind;
    int pick;
    logic [1:0] op;
    board       = new();
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = sat_pkg::OP_WRITE;
    m_tready    = 1'b1;
    cycles      = 0;
    stall_mode  = 0;
    stall_left  = 0;
    burst_left  = 0;
    searched    = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty search, then the unused code with every bit set
    set_section_count(5'd0);
    send_query(sat_pkg::OP_VIRT_QUERY, 32'h0);
    send_query(sat_pkg::OP_FILE_QUERY, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, '1);

    write_entry(4'd0, 32'h0000_1000, 32'h0000_0100, 32'h0000_0400, 32'h0000_0080);
    write_entry(4'd1, 32'h0000_1000, 32'h0000_0010, 32'h0000_0800, 32'h0000_0200);
    write_entry(4'd2, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    write_entry(4'd3, 32'h0, 32'h0, 32'h0, 32'h0);
    write_entry(4'd4, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h1);
    for (int i = 5; i < SECTIONS; i++) write_random_entry(4'(i));

    set_section_count(5'd16);
    send_query(sat_pkg::OP_VIRT_QUERY, 32'h0000_1090);
    send_query(sat_pkg::OP_VIRT_QUERY, 32'h0000_1100);
    send_query(sat_pkg::OP_VIRT_QUERY, 32'h0);
    send_query(sat_pkg::OP_FILE_QUERY, 32'hFFFF_FFFF);
    send_query(sat_pkg::OP_FILE_QUERY, 32'h0000_047F);

    set_section_count(5'd31);
    send_query(sat_pkg::OP_VIRT_QUERY, 32'hFFFF_FFFF);
    send_query(sat_pkg::OP_FILE_QUERY, 32'h0000_0400);

    set_section_count(5'd1);
    send_query(sat_pkg::OP_VIRT_QUERY, 32'h0000_1090);

    for (int p = 0; p < PHASES; p++) begin
      set_section_count((p < 6) ? phase_counts[p] : 5'($urandom_range(0, 31)));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) drain();
        pace();
        kind = $urandom_range(0, 99);
        pick = (searched == 0) ? $urandom_range(0, SECTIONS - 1)
                               : $urandom_range(0, searched - 1);
        if (kind < 15) begin
          write_random_entry($urandom_range(0, 1) ? 4'($urandom_range(0, 3))
                                                  : 4'($urandom_range(0, 15)));
        end else if (kind < 55) begin
          send_query(sat_pkg::OP_VIRT_QUERY,
                     near_address(sat_pkg::OP_VIRT_QUERY, pick));
        end else if (kind < 90) begin
          send_query(sat_pkg::OP_FILE_QUERY,
                     near_address(sat_pkg::OP_FILE_QUERY, pick));
        end else if (kind < 95) begin
          send_query(OP_UNUSED, $urandom());
        end else begin
          op = (kind < 98) ? sat_pkg::OP_VIRT_QUERY : sat_pkg::OP_FILE_QUERY;
          send_query(op, $urandom());
        end
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
